### hw/rtl/radial_stick_deadzone_top_macros.svh
// Assertion macros for the radial stick dead zone block.
`ifndef RADIAL_STICK_DEADZONE_TOP_MACROS_SVH
`define RADIAL_STICK_DEADZONE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define RSD_NEVER(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) else $error(msg);
`else
`define RSD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define RSD_NEVER(lbl, clk_s, rstn_s, expr, msg)
`endif
`endif

### hw/rtl/rsd_pkg.sv
// Shared types and constants for the radial stick dead zone block.
package rsd_pkg;
  localparam int SB = 16;              // sample width
  localparam int RW = SB - 1;          // magnitude register / quotient width
  localparam int SQW = 2 * SB;         // squared sum width
  localparam int NW = SB + RW;         // dividend / divisor width
  localparam int PW = NW + RW;         // dividend times full scale
  localparam int SQRT_LAT = SB;        // one root bit per stage
  localparam int DIV_LAT = RW;         // one quotient bit per stage
  localparam int ST_MAG = 2 + SQRT_LAT;
  localparam int ST_M1 = ST_MAG + 1;
  localparam int ST_M2 = ST_M1 + 1;
  localparam int ST_M3 = ST_M2 + 1;
  localparam int ST_DIV = ST_M3 + DIV_LAT;
  localparam int SIDE_LAT = ST_DIV + 1;
  localparam int PIPE_LAT = SIDE_LAT + 1;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 1'b1;
  localparam logic [RW-1:0] INNER_RST = RW'(3277);
  localparam logic [RW-1:0] OUTER_RST = RW'(29491);
  localparam logic [SB-1:0] MOST_NEG = {1'b1, {RW{1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0] left_x;
    logic signed [SB-1:0] left_y;
    logic signed [SB-1:0] right_x;
    logic signed [SB-1:0] right_y;
    logic signed [SB-1:0] left_trig;
    logic signed [SB-1:0] right_trig;
  } in_t;

  typedef struct packed {
    logic signed [SB-1:0] out_left_x;
    logic signed [SB-1:0] out_left_y;
    logic signed [SB-1:0] out_right_x;
    logic signed [SB-1:0] out_right_y;
    logic [RW-1:0] out_left_trig;
    logic [RW-1:0] out_right_trig;
  } out_t;

  // per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic [1:0][1:0] neg;
    logic [1:0][1:0][SB-1:0] ab;
    logic [1:0][RW-1:0] trig;
  } side_t;
endpackage

### hw/rtl/rsd_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module rsd_sqrt import rsd_pkg::*; (
  input  logic           clk,
  input  logic [SQW-1:0] rad,
  output logic [SB-1:0]  root
);
  logic [SQW-1:0] rem_r  [SQRT_LAT];
  logic [SB-1:0]  root_r [SQRT_LAT];
  logic [SQW-1:0] rem_in [SQRT_LAT];
  logic [SB-1:0]  root_in [SQRT_LAT];

  genvar j;
  generate
    for (j = 0; j < SQRT_LAT; j++) begin : g_stg
      localparam int BI = SB - 1 - j;
      logic [SQW+1:0] trial;
      if (j == 0) begin : g_first
        assign rem_in[j]  = rad;
        assign root_in[j] = '0;
      end else begin : g_next
        assign rem_in[j]  = rem_r[j-1];
        assign root_in[j] = root_r[j-1];
      end
      // (2*root + 2^i) * 2^i, root has no bits at or below i yet
      assign trial = ((SQW+2)'(root_in[j]) << (BI + 1)) | ((SQW+2)'(1) << (2 * BI));
      always_ff @(posedge clk) begin
        if ((SQW+2)'(rem_in[j]) >= trial) begin
          rem_r[j]  <= SQW'((SQW+2)'(rem_in[j]) - trial);
          root_r[j] <= root_in[j] | (SB'(1) << BI);
        end else begin
          rem_r[j]  <= rem_in[j];
          root_r[j] <= root_in[j];
        end
      end
    end
  endgenerate

  assign root = root_r[SQRT_LAT-1];
endmodule

### hw/rtl/rsd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rsd_div import rsd_pkg::*; (
  input  logic          clk,
  input  logic [PW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [RW-1:0] quo
);
  logic [PW-1:0] r_r [DIV_LAT];
  logic [NW-1:0] d_r [DIV_LAT];
  logic [RW-1:0] q_r [DIV_LAT];
  logic [PW-1:0] r_in [DIV_LAT];
  logic [NW-1:0] d_in [DIV_LAT];
  logic [RW-1:0] q_in [DIV_LAT];

  genvar j;
  generate
    for (j = 0; j < DIV_LAT; j++) begin : g_stg
      localparam int BI = RW - 1 - j;
      logic [PW-1:0] ds;
      if (j == 0) begin : g_first
        assign r_in[j] = num;
        assign d_in[j] = den;
        assign q_in[j] = '0;
      end else begin : g_next
        assign r_in[j] = r_r[j-1];
        assign d_in[j] = d_r[j-1];
        assign q_in[j] = q_r[j-1];
      end
      assign ds = PW'(d_in[j]) << BI;
      always_ff @(posedge clk) begin
        d_r[j] <= d_in[j];
        if (r_in[j] >= ds) begin
          r_r[j] <= r_in[j] - ds;
          q_r[j] <= q_in[j] | (RW'(1) << BI);
        end else begin
          r_r[j] <= r_in[j];
          q_r[j] <= q_in[j];
        end
      end
    end
  endgenerate

  assign quo = q_r[DIV_LAT-1];
endmodule

### hw/rtl/radial_stick_deadzone_top.sv
// Top level: radial dead zone with rescaling for two sticks, trigger clamp.
//
//  channel | ports                               | handshake
//  input   | start, busy, in_data                | start && !busy
//  result  | out_valid, out_data                 | one-cycle strobe, no back pressure
//  config  | cfg_we, cfg_idx, cfg_wdata          | write on cfg_we
//
// One report per cycle while busy is low; each taken report yields one result.
// Latency is set by the 16-stage root and the 15-stage divider, one bit per stage.
// busy is high only while rst_n is low; reset drops everything in flight.
// The pipeline never stalls: the receiver has no way to hold results.
`include "radial_stick_deadzone_top_macros.svh"
module radial_stick_deadzone_top import rsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [RW-1:0]        cfg_wdata
);
  logic [RW-1:0] inner_r, outer_r;
  logic          in_acc;
  side_t         side_nxt;
  side_t         side_r [SIDE_LAT];
  logic [SIDE_LAT-1:0] vld_r;

  logic [1:0][1:0][SQW-1:0] sq_r;
  logic [1:0][SQW-1:0]      sum_r;
  logic [1:0][SB-1:0]       mag;
  logic [1:0][SB-1:0]       mag1_r;
  logic [1:0][RW-1:0]       num_r, w_r;
  logic [1:0]               zero_r, byp_r;
  logic [1:0][1:0][NW-1:0]  n_r;
  logic [1:0][NW-1:0]       d_r;
  logic [1:0][1:0][PW-1:0]  p_r;
  logic [1:0][NW-1:0]       d2_r;
  logic [1:0][1:0][RW-1:0]  quo;
  logic [1:0][1:0][SB-1:0]  comp;
  logic                     out_vld_r;
  out_t                     out_r;
  logic                     out_most_neg;

  assign busy   = ~rst_n;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RST;
      outer_r <= OUTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INNER: inner_r <= cfg_wdata;
        CFG_OUTER: outer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 0: signs, absolute values, trigger clamp
  always_comb begin
    logic [1:0][1:0][SB-1:0] raw;
    raw[0][0] = in_data.left_x;
    raw[0][1] = in_data.left_y;
    raw[1][0] = in_data.right_x;
    raw[1][1] = in_data.right_y;
    for (int s = 0; s < 2; s++) begin
      for (int a = 0; a < 2; a++) begin
        side_nxt.neg[s][a] = raw[s][a][SB-1];
        side_nxt.ab[s][a]  = raw[s][a][SB-1] ? (~raw[s][a] + SB'(1)) : raw[s][a];
      end
    end
    side_nxt.trig[0] = in_data.left_trig[SB-1] ? '0 : in_data.left_trig[RW-1:0];
    side_nxt.trig[1] = in_data.right_trig[SB-1] ? '0 : in_data.right_trig[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[SIDE_LAT-2:0], in_acc};
      out_vld_r <= vld_r[SIDE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int k = 1; k < SIDE_LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  genvar s;
  generate
    for (s = 0; s < 2; s++) begin : g_stick
      // stages 1 and 2: squares, then sum of squares
      always_ff @(posedge clk) begin
        sq_r[s][0] <= side_r[0].ab[s][0] * side_r[0].ab[s][0];
        sq_r[s][1] <= side_r[0].ab[s][1] * side_r[0].ab[s][1];
        sum_r[s]   <= sq_r[s][0] + sq_r[s][1];
      end

      rsd_sqrt u_sqrt (.clk(clk), .rad(sum_r[s]), .root(mag[s]));

      // zone decisions on the magnitude
      always_ff @(posedge clk) begin
        mag1_r[s] <= mag[s];
        zero_r[s] <= (mag[s] == '0) || (mag[s] <= SB'(inner_r));
        byp_r[s]  <= (outer_r <= inner_r) || (mag[s] >= SB'(outer_r));
        num_r[s]  <= RW'(mag[s] - SB'(inner_r));
        w_r[s]    <= outer_r - inner_r;
      end

      // dividend and divisor; dead zone divides zero by one
      always_ff @(posedge clk) begin
        if (zero_r[s]) begin
          n_r[s][0] <= '0;
          n_r[s][1] <= '0;
          d_r[s]    <= NW'(1);
        end else if (byp_r[s]) begin
          n_r[s][0] <= NW'(side_r[ST_M1].ab[s][0]);
          n_r[s][1] <= NW'(side_r[ST_M1].ab[s][1]);
          d_r[s]    <= NW'(mag1_r[s]);
        end else begin
          n_r[s][0] <= NW'(side_r[ST_M1].ab[s][0]) * NW'(num_r[s]);
          n_r[s][1] <= NW'(side_r[ST_M1].ab[s][1]) * NW'(num_r[s]);
          d_r[s]    <= NW'(mag1_r[s]) * NW'(w_r[s]);
        end
      end

      // times full scale: n * 2^15 - n
      always_ff @(posedge clk) begin
        p_r[s][0] <= (PW'(n_r[s][0]) << RW) - PW'(n_r[s][0]);
        p_r[s][1] <= (PW'(n_r[s][1]) << RW) - PW'(n_r[s][1]);
        d2_r[s]   <= d_r[s];
      end

      rsd_div u_div_x (.clk(clk), .num(p_r[s][0]), .den(d2_r[s]), .quo(quo[s][0]));
      rsd_div u_div_y (.clk(clk), .num(p_r[s][1]), .den(d2_r[s]), .quo(quo[s][1]));

      assign comp[s][0] = side_r[ST_DIV].neg[s][0] ? (~SB'(quo[s][0]) + SB'(1))
                                                   : SB'(quo[s][0]);
      assign comp[s][1] = side_r[ST_DIV].neg[s][1] ? (~SB'(quo[s][1]) + SB'(1))
                                                   : SB'(quo[s][1]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    out_r.out_left_x     <= comp[0][0];
    out_r.out_left_y     <= comp[0][1];
    out_r.out_right_x    <= comp[1][0];
    out_r.out_right_y    <= comp[1][1];
    out_r.out_left_trig  <= side_r[ST_DIV].trig[0];
    out_r.out_right_trig <= side_r[ST_DIV].trig[1];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign out_most_neg = (out_data.out_left_x == MOST_NEG) ||
                        (out_data.out_left_y == MOST_NEG) ||
                        (out_data.out_right_x == MOST_NEG) ||
                        (out_data.out_right_y == MOST_NEG);

  `RSD_ASSERT(a_latency, clk, rst_n, out_valid |-> $past(in_acc, PIPE_LAT), "result without a transaction")
  `RSD_NEVER(a_range, clk, rst_n, out_valid && out_most_neg, "stick output beyond full scale")
  `RSD_NEVER(a_cfg_busy, clk, rst_n, busy && vld_r[0], "transaction taken while busy")
endmodule
